FILE: sv/ipv4_dotted_quad_validator_top_defines.svh
// assertion macros shared by the block
`ifndef IPV4_DOTTED_QUAD_VALIDATOR_TOP_DEFINES_SVH
`define IPV4_DOTTED_QUAD_VALIDATOR_TOP_DEFINES_SVH

// same-cycle implication
`define IPV4DQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPV4DQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ipv4dq_pkg.sv
`timescale 1ns / 1ps
package ipv4dq_pkg;

    localparam logic [7:0] CharNul  = 8'h00;
    localparam logic [7:0] CharDot  = 8'h2E;
    localparam logic [7:0] CharZero = 8'h30;
    localparam logic [7:0] CharOne  = 8'h31;
    localparam logic [7:0] CharNine = 8'h39;

    localparam logic [9:0] MaxOctet    = 10'd255;
    localparam logic [2:0] MaxTokLen   = 3'd3;
    localparam logic [2:0] TokLenSat   = 3'd4;
    localparam logic [2:0] TokCountSat = 3'd5;
    localparam logic [2:0] TokCountOk  = 3'd4;
    localparam logic [2:0] ZeroOctSat  = 3'd7;
    localparam logic [1:0] LeadZeroSat = 2'd3;

    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 1;
    localparam logic [CfgIdxW-1:0] CfgZeroOk  = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgEmptyOk = 1'b1;

    typedef struct packed {
        logic valid;
        logic status;
    } t_result;

    typedef struct packed {
        logic       block;
        logic [1:0] cnt_eff;
    } t_qstat;

endpackage

FILE: sv/ipv4_dotted_quad_validator_top.sv
`timescale 1ns / 1ps
// channel   dir   handshake            payload
// ch        in    i_valid / o_stall    i_ch[7:0]
// status    out   o_valid / i_stall    o_status
// cfg       in    i_cfg_we             i_cfg_idx, i_cfg_data
// one character beat per cycle while o_stall is low; a verdict passes from its nul beat
// through the input register into the two-entry result queue
// reset is synchronous, active low: zero_ok = 1, empty_ok = 0, string state cleared
// o_stall rises when the result queue is full, or holds one verdict while a beat waits in the parse register
`include "ipv4_dotted_quad_validator_top_defines.svh"
module ipv4_dotted_quad_validator_top
    import ipv4dq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_ch,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_status,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    logic    w_accept;
    logic    w_pending;
    t_result w_res;
    t_qstat  w_qstat;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = w_qstat.block;

    ipv4dq_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_ch       (i_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pending  (w_pending),
        .o_res      (w_res)
    );

    ipv4dq_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (w_res),
        .i_pending (w_pending),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_status  (o_status),
        .o_qstat   (w_qstat)
    );

    `IPV4DQ_ASSERT_NOW(a_no_overflow, w_res.valid, w_qstat.cnt_eff != 2'd2, "result queue overflow")
    `IPV4DQ_ASSERT_NEXT(a_nul_gives_verdict, w_accept && (i_ch == CharNul), w_res.valid, "nul beat without verdict")
    `IPV4DQ_ASSERT_NOW(a_verdict_from_nul, w_res.valid, $past(w_accept && (i_ch == CharNul)), "verdict without nul beat")

endmodule

FILE: sv/ipv4dq_parse.sv
`timescale 1ns / 1ps
module ipv4dq_parse
    import ipv4dq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_ch,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output logic                o_pending,
    output t_result             o_res
);

    typedef struct packed {
        logic [2:0] token_count;
        logic [2:0] token_len;
        logic [1:0] lead_zeros;
        logic       nonzero_seen;
        logic [9:0] octet_value;
        logic [2:0] zero_octets;
        logic       bad_flag;
        logic       in_token;
        logic       any_char;
    } t_state;

    logic       r_ch_valid;
    logic [7:0] r_ch;
    logic       r_zero_ok;
    logic       r_empty_ok;
    t_state     r_st;
    t_state     n_st;
    t_state     w_fin;
    logic       w_status;

    function automatic t_state finish_token(t_state s);
        t_state     f;
        logic [1:0] allowed;
        f = s;
        allowed = (s.octet_value != 10'd0) ? 2'd0 : 2'd1;
        if ((s.lead_zeros > allowed) || (s.octet_value > MaxOctet)) begin
            f.bad_flag = 1'b1;
        end
        if ((s.octet_value == 10'd0) && (s.zero_octets < ZeroOctSat)) begin
            f.zero_octets = s.zero_octets + 3'd1;
        end
        if (s.token_count < TokCountSat) begin
            f.token_count = s.token_count + 3'd1;
        end
        f.token_len    = 3'd0;
        f.lead_zeros   = 2'd0;
        f.nonzero_seen = 1'b0;
        f.octet_value  = 10'd0;
        f.in_token     = 1'b0;
        return f;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_valid <= 1'b0;
            r_zero_ok  <= 1'b1;
            r_empty_ok <= 1'b0;
            r_st       <= '0;
        end else begin
            r_ch_valid <= i_accept;
            if (r_ch_valid) begin
                r_st <= n_st;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgZeroOk:  r_zero_ok  <= i_cfg_data[0];
                    CfgEmptyOk: r_empty_ok <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ch <= i_ch;
        end
    end

    assign w_fin = r_st.in_token ? finish_token(r_st) : r_st;

    always_comb begin
        if (!r_st.any_char) begin
            w_status = !r_empty_ok;
        end else if (w_fin.bad_flag || (w_fin.token_count != TokCountOk)) begin
            w_status = 1'b1;
        end else if (!r_zero_ok && (w_fin.zero_octets == TokCountOk)) begin
            w_status = 1'b1;
        end else begin
            w_status = 1'b0;
        end
    end

    always_comb begin
        n_st = r_st;
        priority if (r_ch == CharNul) begin
            n_st = '0;
        end else if (r_ch == CharDot) begin
            n_st = w_fin;
            n_st.any_char = 1'b1;
        end else begin
            n_st.any_char = 1'b1;
            n_st.in_token = 1'b1;
            if (r_st.token_len < TokLenSat) begin
                n_st.token_len = r_st.token_len + 3'd1;
            end
            if (n_st.token_len > MaxTokLen) begin
                n_st.bad_flag = 1'b1;
            end else if ((r_ch < CharZero) || (r_ch > CharNine)) begin
                n_st.bad_flag = 1'b1;
            end else begin
                if (r_ch >= CharOne) begin
                    n_st.nonzero_seen = 1'b1;
                end else if (!r_st.nonzero_seen && (r_st.lead_zeros < LeadZeroSat)) begin
                    n_st.lead_zeros = r_st.lead_zeros + 2'd1;
                end
                // value * 10 + digit, kept to ten bits
                n_st.octet_value = {r_st.octet_value[6:0], 3'b000}
                                 + {r_st.octet_value[8:0], 1'b0}
                                 + {6'd0, r_ch[3:0]};
            end
        end
    end

    assign o_pending    = r_ch_valid;
    assign o_res.valid  = r_ch_valid && (r_ch == CharNul);
    assign o_res.status = w_status;

endmodule

FILE: sv/ipv4dq_outq.sv
`timescale 1ns / 1ps
module ipv4dq_outq
    import ipv4dq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_res,
    input  logic    i_pending,
    input  logic    i_stall,
    output logic    o_valid,
    output logic    o_status,
    output t_qstat  o_qstat
);

    logic [1:0] r_q;
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;
    logic [1:0] w_cnt_eff;

    assign w_pop     = (r_cnt != 2'd0) && !i_stall;
    assign w_cnt_eff = r_cnt - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_res.valid) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= w_cnt_eff + {1'b0, i_res.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_q[r_wp] <= i_res.status;
        end
    end

    assign o_valid         = (r_cnt != 2'd0);
    assign o_status        = r_q[r_rp];
    assign o_qstat.cnt_eff = w_cnt_eff;
    // one beat may still be in the parse register
    assign o_qstat.block   = (w_cnt_eff == 2'd2) || ((w_cnt_eff == 2'd1) && i_pending);

endmodule

FILE: verif/tb_ipv4_dotted_quad_validator_top.sv
`timescale 1ns / 1ps
module tb_ipv4_dotted_quad_validator_top;
    import ipv4dq_pkg::*;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic                o_stall;
    logic [7:0]          i_ch       = CharNul;
    logic                o_valid;
    logic                i_stall    = 1'b0;
    logic                o_status;
    logic                i_cfg_we   = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx  = CfgZeroOk;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    ipv4_dotted_quad_validator_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_ch       (i_ch),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow registers and string state of the validator
    logic       zero_ok_m  = 1'b1;
    logic       empty_ok_m = 1'b0;
    logic [2:0] tok_cnt    = '0;
    logic [2:0] tok_len    = '0;
    logic [1:0] lz_cnt     = '0;
    logic       nz_seen    = 1'b0;
    logic [9:0] oct_val    = '0;
    logic [2:0] zero_cnt   = '0;
    logic       bad        = 1'b0;
    logic       in_tok     = 1'b0;
    logic       seen_char  = 1'b0;

    logic [7:0] pend_q[$];
    logic       verdict_q[$];

    logic rst_done  = 1'b0;
    logic ch_taken  = 1'b0;
    logic idle_on   = 1'b0;
    int   gap_left  = 0;
    int   stall_left = 0;
    int   long_hold = 0;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   pushed    = 0;
    int   chars_in  = 0;
    int   verdicts  = 0;
    int   fails     = 0;
    int   settings  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("ipv4_dotted_quad_validator_top regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int rand_octet();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 0;
        if (r == 3) return 255;
        if (r < 6) return $urandom_range(0, 9);
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CharDot || (b >= CharZero && b <= CharNine));
        return b;
    endfunction

    task automatic close_octet();
        if ((oct_val != 0 && lz_cnt != 0) || (oct_val == 0 && lz_cnt > 2'd1) ||
            oct_val > MaxOctet)
            bad = 1'b1;
        if (oct_val == 0 && zero_cnt < ZeroOctSat)
            zero_cnt = zero_cnt + 3'd1;
        if (tok_cnt < TokCountSat)
            tok_cnt = tok_cnt + 3'd1;
        tok_len = '0;
        lz_cnt  = '0;
        nz_seen = 1'b0;
        oct_val = '0;
        in_tok  = 1'b0;
    endtask

    task automatic predict_char(input logic [7:0] c);
        logic st;
        if (c == CharNul) begin
            if (in_tok)
                close_octet();
            if (!seen_char)
                st = !empty_ok_m;
            else if (bad || tok_cnt != TokCountOk)
                st = 1'b1;
            else if (!zero_ok_m && zero_cnt == TokCountOk)
                st = 1'b1;
            else
                st = 1'b0;
            verdict_q = {verdict_q, st};
            tok_cnt   = '0;
            tok_len   = '0;
            lz_cnt    = '0;
            nz_seen   = 1'b0;
            oct_val   = '0;
            zero_cnt  = '0;
            bad       = 1'b0;
            in_tok    = 1'b0;
            seen_char = 1'b0;
        end else begin
            seen_char = 1'b1;
            if (c == CharDot) begin
                if (in_tok)
                    close_octet();
            end else begin
                in_tok = 1'b1;
                if (tok_len < TokLenSat)
                    tok_len = tok_len + 3'd1;
                if (tok_len > MaxTokLen) begin
                    bad = 1'b1;
                end else if (c >= CharZero && c <= CharNine) begin
                    if (c == CharZero) begin
                        if (!nz_seen && lz_cnt < LeadZeroSat)
                            lz_cnt = lz_cnt + 2'd1;
                    end else begin
                        nz_seen = 1'b1;
                    end
                    oct_val = 10'(oct_val * 10 + (c - CharZero));
                end else begin
                    bad = 1'b1;
                end
            end
        end
    endtask

    // input beats, config writes and verdict beats, all sampled at the rising edge
    always @(posedge i_clk) begin
        ch_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgZeroOk:  zero_ok_m  = i_cfg_data[0];
                    CfgEmptyOk: empty_ok_m = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                chars_in++;
                predict_char(i_ch);
            end
            if (o_valid && !i_stall) begin
                verdicts++;
                if (verdict_q.size() == 0) begin
                    $error("status: no verdict expected, actual %0b", o_status);
                    fails++;
                end else if (o_status !== verdict_q[0]) begin
                    $error("status: expected %0b, actual %0b", verdict_q[0], o_status);
                    fails++;
                    void'(verdict_q.pop_front());
                end else begin
                    void'(verdict_q.pop_front());
                end
            end
        end
    end

    // character driver
    always @(negedge i_clk) begin
        if (!rst_done) begin
            i_valid <= 1'b0;
        end else if (i_valid && !ch_taken) begin
            // stalled beat holds
        end else if (gap_left > 0) begin
            i_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pend_q.size() > 0) begin
            i_ch     <= pend_q.pop_front();
            i_valid  <= 1'b1;
            gap_left <= idle_on ? pick_gap() : 0;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // verdict receiver stall
    always @(negedge i_clk) begin
        if (!rst_done) begin
            i_stall <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            long_hold <= 80;
            i_stall   <= 1'b1;
        end else if (long_hold > 0) begin
            i_stall   <= 1'b1;
            long_hold <= long_hold - 1;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= pick_gap();
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        pend_q = {pend_q, b};
        pushed++;
    endtask

    task automatic push_text(input string s);
        foreach (s[i])
            push_byte(s[i]);
    endtask

    task automatic push_dots(input int n);
        for (int k = 0; k < n; k++)
            push_byte(CharDot);
    endtask

    task automatic gen_string();
        int kind;
        int cnt;
        int bad_pos;
        int sub;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            if ($urandom_range(0, 1))
                push_text("0.0.0.0");
        end else if (kind < 22) begin
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 3))
                    0: push_byte(CharDot);
                    1: push_byte(8'(CharZero + $urandom_range(0, 9)));
                    default: push_byte(8'($urandom_range(1, 255)));
                endcase
            end
        end else begin
            cnt = 4;
            bad_pos = -1;
            sub = 0;
            if (kind >= 70) begin
                sub = $urandom_range(0, 5);
                if (sub == 0) begin
                    cnt = $urandom_range(1, 7);
                    if (cnt >= 4)
                        cnt++;
                end else begin
                    bad_pos = $urandom_range(0, cnt - 1);
                end
            end
            if ($urandom_range(0, 5) == 0)
                push_dots($urandom_range(1, 2));
            for (int k = 0; k < cnt; k++) begin
                if (k > 0)
                    push_dots($urandom_range(0, 7) == 0 ? $urandom_range(2, 3) : 1);
                if (k != bad_pos) begin
                    push_text($sformatf("%0d", rand_octet()));
                end else begin
                    case (sub)
                        1: begin
                            // leading zeros
                            repeat ($urandom_range(1, 3)) push_byte(CharZero);
                            push_text($sformatf("%0d", rand_octet()));
                        end
                        2: push_text($sformatf("%0d", $urandom_range(256, 999)));
                        3: begin
                            n = $urandom_range(4, 6);
                            for (int j = 0; j < n; j++)
                                push_byte(8'(CharZero + $urandom_range(0, 9)));
                        end
                        default: begin
                            push_text($sformatf("%0d", $urandom_range(0, 99)));
                            push_byte(stray_byte());
                            if ($urandom_range(0, 1))
                                push_byte(8'(CharZero + $urandom_range(0, 9)));
                        end
                    endcase
                end
            end
            if ($urandom_range(0, 5) == 0)
                push_dots($urandom_range(1, 2));
        end
        push_byte(CharNul);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_all();
        while (pend_q.size() != 0 || i_valid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int start;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;

        // directed strings under reset settings, no idling
        push_byte(CharNul);
        push_text("..");
        push_byte(CharNul);
        push_text("0.0.0.0");
        push_byte(CharNul);
        push_text(".1..255.0.9.");
        push_byte(CharNul);
        push_byte(8'hFF);
        push_byte(CharNul);
        drain_all();
        settings++;

        idle_on = 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CfgZeroOk, CfgDataW'(ph[0]));
            write_reg(CfgEmptyOk, CfgDataW'(!ph[1]));
            settings++;
            if (ph == 1) begin
                // receiver holds off while the sender keeps offering beats
                idle_on = 1'b0;
                hold_reqs++;
                repeat (12) gen_string();
                drain_all();
                idle_on = 1'b1;
            end
            start = pushed;
            while (pushed - start < 150)
                gen_string();
            drain_all();
        end

        repeat (10) @(posedge i_clk);
        $display("covered %0d character beats and %0d verdicts over %0d register settings,",
                 chars_in, verdicts, settings);
        $display("with random gaps on both sides and one long verdict hold-off");
        if (fails == 0)
            $display("ipv4_dotted_quad_validator_top regression: pass");
        else
            $display("ipv4_dotted_quad_validator_top regression: fail");
        $finish;
    end

endmodule
